FILE: hw/rtl/ptsq_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ptsq_pkg
// Shared widths, constants, arctangent table and pipeline types for the
// polar to square-clipped XY unit.
// -----------------------------------------------------------------------------
package ptsq_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;
   localparam int CORDIC_LEN   = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

   localparam int AZ_W        = 16;
   localparam int DV_W        = 11;
   localparam int POS_W       = 16;
   localparam int WRAP_W      = 18;
   localparam int FOLD_W      = 14;
   localparam int ANGLE_FRAC  = 12;
   localparam int ANG_W       = 27;
   localparam int SCALE_W     = 23;
   localparam int VEC_W       = DV_W + SCALE_W;
   localparam int XY_W        = 17;
   localparam int ROUND_SHIFT = 16;
   localparam int NUM_W       = 30;
   localparam int DEN_W       = 16;
   localparam int QUO_W       = 16;
   localparam int CLIP_STAGES = 4;

   localparam int TURN_UNITS    = 23040;
   localparam int HALF_UNITS    = 11520;
   localparam int QUARTER_UNITS = 5760;
   localparam int START_SCALE   = 1440803;
   localparam int EDGE_Q8       = 25600;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   function automatic logic signed [ANG_W-1:0] atan_units(input int idx);
      logic signed [ANG_W-1:0] val;
      case (idx)
         0:       val = ANG_W'(11796480);
         1:       val = ANG_W'(6963869);
         2:       val = ANG_W'(3679517);
         3:       val = ANG_W'(1867780);
         4:       val = ANG_W'(937515);
         5:       val = ANG_W'(469214);
         6:       val = ANG_W'(234664);
         7:       val = ANG_W'(117339);
         8:       val = ANG_W'(58671);
         9:       val = ANG_W'(29335);
         10:      val = ANG_W'(14668);
         11:      val = ANG_W'(7334);
         12:      val = ANG_W'(3667);
         13:      val = ANG_W'(1833);
         14:      val = ANG_W'(917);
         15:      val = ANG_W'(458);
         16:      val = ANG_W'(229);
         17:      val = ANG_W'(115);
         18:      val = ANG_W'(57);
         19:      val = ANG_W'(29);
         20:      val = ANG_W'(14);
         21:      val = ANG_W'(7);
         22:      val = ANG_W'(4);
         23:      val = ANG_W'(2);
         default: val = '0;
      endcase
      return val;
   endfunction

   typedef struct packed {
      logic                    valid;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
   } xy_type;

   typedef struct packed {
      logic                    valid;
      logic                    clip;
      logic                    sel_y;
      logic                    neg;
      logic [NUM_W-1:0]        num;
      logic [DEN_W-1:0]        den;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
   } div_in_type;

endpackage

FILE: hw/rtl/ptsq_div.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ptsq_div
// Pipelined restoring divider, one quotient bit per stage, followed by a stage
// that signs the quotient and writes it into the clipped point.
// -----------------------------------------------------------------------------
module ptsq_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  ptsq_pkg::div_in_type din,
   output ptsq_pkg::xy_type     dout
);
   import ptsq_pkg::*;

   typedef struct packed {
      logic                    valid;
      logic                    clip;
      logic                    sel_y;
      logic                    neg;
      logic [NUM_W-1:0]        rem;
      logic [QUO_W-1:0]        quo;
      logic [DEN_W-1:0]        den;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
   } step_type;

   step_type step_src [QUO_W];
   step_type step_in  [QUO_W];
   step_type step_ff  [QUO_W];
   xy_type   out_in;
   xy_type   out_ff;

   always_comb begin
      step_src[0].valid = din.valid;
      step_src[0].clip  = din.clip;
      step_src[0].sel_y = din.sel_y;
      step_src[0].neg   = din.neg;
      step_src[0].rem   = din.num;
      step_src[0].quo   = '0;
      step_src[0].den   = din.den;
      step_src[0].x     = din.x;
      step_src[0].y     = din.y;
      for (int j = 1; j < QUO_W; j++) begin
         step_src[j] = step_ff[j-1];
      end
   end

   // restoring step: bit QUO_W-1-j of the quotient
   always_comb begin
      logic [NUM_W:0] trial;
      for (int j = 0; j < QUO_W; j++) begin
         step_in[j] = step_src[j];
         trial = (NUM_W+1)'(step_src[j].den) << (QUO_W - 1 - j);
         if ({1'b0, step_src[j].rem} >= trial) begin
            step_in[j].rem = step_src[j].rem - trial[NUM_W-1:0];
            step_in[j].quo[QUO_W-1-j] = 1'b1;
         end
      end
   end

   always_comb begin
      logic signed [XY_W-1:0] qs;
      qs = $signed({1'b0, step_ff[QUO_W-1].quo});
      if (step_ff[QUO_W-1].neg) begin
         qs = -qs;
      end
      out_in.valid = step_ff[QUO_W-1].valid;
      out_in.x     = step_ff[QUO_W-1].x;
      out_in.y     = step_ff[QUO_W-1].y;
      if (step_ff[QUO_W-1].clip) begin
         if (step_ff[QUO_W-1].sel_y) begin
            out_in.y = qs;
         end else begin
            out_in.x = qs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < QUO_W; j++) begin
            step_ff[j].valid <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end else if (en) begin
         for (int j = 0; j < QUO_W; j++) begin
            step_ff[j] <= step_in[j];
         end
         out_ff <= out_in;
      end
   end

   assign dout = out_ff;

endmodule

FILE: hw/rtl/polar_to_square_clipped_xy_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// polar_to_square_clipped_xy_unit
// Azimuth/distance to XY via a fully unrolled CORDIC, then clipping onto the
// square of side 200 by sliding the point along its ray.
// Pipeline stages: wrap/scale, one stage per CORDIC step, rounding, four clip
// passes of 18 stages each, output register.
// Throughput: one transaction per cycle while the output is not stalled; each
// clip divider retires one quotient bit per stage.
// Reset clears all valid bits; the block holds no other state.
// -----------------------------------------------------------------------------
module polar_to_square_clipped_xy_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ptsq_pkg::REQ_DATA_W-1:0] req_tdata,   // azimuth[15:0], diverge[26:16]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ptsq_pkg::RSP_DATA_W-1:0] rsp_tdata    // x_pos[15:0], y_pos[31:16]
);
   import ptsq_pkg::*;

   typedef struct packed {
      logic                     valid;
      logic                     flip;
      logic signed [VEC_W-1:0]  c;
      logic signed [VEC_W-1:0]  s;
      logic signed [ANG_W-1:0]  z;
   } cordic_type;

   localparam logic signed [WRAP_W-1:0]  TURN_S    = WRAP_W'(TURN_UNITS);
   localparam logic signed [WRAP_W-1:0]  HALF_S    = WRAP_W'(HALF_UNITS);
   localparam logic signed [WRAP_W-1:0]  QUARTER_S = WRAP_W'(QUARTER_UNITS);
   localparam logic signed [SCALE_W-1:0] SCALE_S   = SCALE_W'(START_SCALE);
   localparam logic signed [VEC_W:0]     ROUND_S   = (VEC_W+1)'(1) <<< (ROUND_SHIFT - 1);
   localparam logic signed [XY_W-1:0]    EDGE_XY   = XY_W'(EDGE_Q8);
   localparam logic signed [XY_W-1:0]    NEDGE_XY  = -XY_W'(EDGE_Q8);

   logic                     en;
   logic                     hold;
   logic                     req_fire;

   cordic_type               head_in;
   cordic_type               cor_src [CORDIC_LEN];
   cordic_type               cor_in  [CORDIC_LEN];
   cordic_type               cor_ff  [CORDIC_LEN];
   cordic_type               head_ff;
   xy_type                   rnd_in;
   xy_type                   rnd_ff;
   xy_type                   clip_src [CLIP_STAGES];
   xy_type                   clip_out [CLIP_STAGES];
   div_in_type               pre_in   [CLIP_STAGES];
   div_in_type               pre_ff   [CLIP_STAGES];
   xy_type                   rsp_ff;

   // bubbles are squeezed out only ahead of the output register
   assign hold       = rsp_ff.valid && !rsp_tready;
   assign en         = !hold || !clip_out[CLIP_STAGES-1].valid;
   assign req_tready = en;
   assign req_fire   = req_tvalid && req_tready;

   // wrap to one turn, fold into +-90 deg, scale the distance
   always_comb begin
      logic signed [AZ_W-1:0]          az;
      logic signed [DV_W-1:0]          dv;
      logic signed [WRAP_W-1:0]        az_x;
      logic signed [WRAP_W-1:0]        w;
      logic signed [WRAP_W-1:0]        f;
      logic                            flip;
      logic signed [DV_W+SCALE_W-1:0]  prod;
      az   = $signed(req_tdata[AZ_W-1:0]);
      dv   = $signed(req_tdata[AZ_W+DV_W-1:AZ_W]);
      az_x = WRAP_W'(az);
      if (az_x < 0) begin
         w = (az_x < -TURN_S) ? (az_x + TURN_S + TURN_S) : (az_x + TURN_S);
      end else if (az_x >= TURN_S) begin
         w = az_x - TURN_S;
      end else begin
         w = az_x;
      end
      if (w >= HALF_S) begin
         w = w - TURN_S;
      end
      flip = 1'b0;
      f    = w;
      if (w > QUARTER_S) begin
         f    = w - HALF_S;
         flip = 1'b1;
      end else if (w < -QUARTER_S) begin
         f    = w + HALF_S;
         flip = 1'b1;
      end
      prod          = dv * SCALE_S;
      head_in.valid = req_fire;
      head_in.flip  = flip;
      head_in.c     = prod;
      head_in.s     = '0;
      head_in.z     = ANG_W'($signed(f[FOLD_W-1:0])) <<< ANGLE_FRAC;
   end

   always_comb begin
      cor_src[0] = head_ff;
      for (int i = 1; i < CORDIC_LEN; i++) begin
         cor_src[i] = cor_ff[i-1];
      end
   end

   always_comb begin
      for (int i = 0; i < CORDIC_LEN; i++) begin
         cor_in[i] = cor_src[i];
         if (!cor_src[i].z[ANG_W-1]) begin
            cor_in[i].c = cor_src[i].c - (cor_src[i].s >>> i);
            cor_in[i].s = cor_src[i].s + (cor_src[i].c >>> i);
            cor_in[i].z = cor_src[i].z - atan_units(i);
         end else begin
            cor_in[i].c = cor_src[i].c + (cor_src[i].s >>> i);
            cor_in[i].s = cor_src[i].s - (cor_src[i].c >>> i);
            cor_in[i].z = cor_src[i].z + atan_units(i);
         end
      end
   end

   // half-turn fold negates both results; round Q24 to Q8
   always_comb begin
      logic signed [VEC_W:0] sx;
      logic signed [VEC_W:0] sy;
      if (cor_ff[CORDIC_LEN-1].flip) begin
         sx = ROUND_S - (VEC_W+1)'(cor_ff[CORDIC_LEN-1].s);
         sy = ROUND_S - (VEC_W+1)'(cor_ff[CORDIC_LEN-1].c);
      end else begin
         sx = (VEC_W+1)'(cor_ff[CORDIC_LEN-1].s) + ROUND_S;
         sy = (VEC_W+1)'(cor_ff[CORDIC_LEN-1].c) + ROUND_S;
      end
      rnd_in.valid = cor_ff[CORDIC_LEN-1].valid;
      rnd_in.x     = sx[ROUND_SHIFT+XY_W-1:ROUND_SHIFT];
      rnd_in.y     = sy[ROUND_SHIFT+XY_W-1:ROUND_SHIFT];
   end

   always_comb begin
      clip_src[0] = rnd_ff;
      for (int k = 1; k < CLIP_STAGES; k++) begin
         clip_src[k] = clip_out[k-1];
      end
   end

   // clip order: x high, y high, x low, y low
   always_comb begin
      logic signed [XY_W-1:0] old_v;
      logic signed [XY_W-1:0] other_v;
      logic [XY_W-1:0]        abs_old;
      logic [XY_W-1:0]        abs_other;
      logic                   upper;
      logic                   on_y;
      logic                   clip;
      for (int k = 0; k < CLIP_STAGES; k++) begin
         on_y      = (k % 2) == 1;
         upper     = k < 2;
         old_v     = on_y ? clip_src[k].y : clip_src[k].x;
         other_v   = on_y ? clip_src[k].x : clip_src[k].y;
         clip      = upper ? (old_v > EDGE_XY) : (old_v < NEDGE_XY);
         abs_old   = old_v[XY_W-1] ? XY_W'(-old_v) : XY_W'(old_v);
         abs_other = other_v[XY_W-1] ? XY_W'(-other_v) : XY_W'(other_v);
         pre_in[k].valid = clip_src[k].valid;
         pre_in[k].clip  = clip;
         pre_in[k].sel_y = !on_y;
         pre_in[k].neg   = other_v[XY_W-1];
         pre_in[k].den   = abs_old[DEN_W-1:0];
         pre_in[k].num   = NUM_W'(abs_other[DEN_W-1:0]) * NUM_W'(EDGE_Q8)
                         + NUM_W'(abs_old[DEN_W-1:1]);
         pre_in[k].x     = clip_src[k].x;
         pre_in[k].y     = clip_src[k].y;
         if (clip) begin
            if (on_y) begin
               pre_in[k].y = upper ? EDGE_XY : NEDGE_XY;
            end else begin
               pre_in[k].x = upper ? EDGE_XY : NEDGE_XY;
            end
         end
      end
   end

   for (genvar k = 0; k < CLIP_STAGES; k++) begin : g_clip
      ptsq_div u_div (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .din   (pre_ff[k]),
         .dout  (clip_out[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
         for (int i = 0; i < CORDIC_LEN; i++) begin
            cor_ff[i].valid <= 1'b0;
         end
         rnd_ff.valid <= 1'b0;
         for (int k = 0; k < CLIP_STAGES; k++) begin
            pre_ff[k].valid <= 1'b0;
         end
         rsp_ff.valid <= 1'b0;
      end else begin
         if (en) begin
            head_ff <= head_in;
            for (int i = 0; i < CORDIC_LEN; i++) begin
               cor_ff[i] <= cor_in[i];
            end
            rnd_ff <= rnd_in;
            for (int k = 0; k < CLIP_STAGES; k++) begin
               pre_ff[k] <= pre_in[k];
            end
         end
         if (!hold) begin
            rsp_ff <= clip_out[CLIP_STAGES-1];
         end
      end
   end

   assign rsp_tvalid = rsp_ff.valid;
   assign rsp_tdata  = {rsp_ff.y[POS_W-1:0], rsp_ff.x[POS_W-1:0]};

`ifndef SYNTHESIS
   a_first_clip : assert property (@(posedge clock) disable iff (reset)
      clip_out[0].valid |-> clip_out[0].x <= EDGE_XY)
      else $error("x above upper edge after first clip pass");

   a_out_square : assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid |-> (rsp_ff.x <= EDGE_XY) && (rsp_ff.x >= NEDGE_XY)
                    && (rsp_ff.y <= EDGE_XY) && (rsp_ff.y >= NEDGE_XY))
      else $error("result outside the square");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule
